// ----- rtl/sgda_pkg.sv -----
// Shared types, codes and defaults of the greedy MaxSAT assigner.
package sgda_pkg;

    localparam int MAX_VARS_DEF     = 1024;
    localparam int MAX_CLAUSES_DEF  = 1024;
    localparam int MAX_LITERALS_DEF = 4096;

    localparam int IDX_W  = 10;
    localparam int NVAR_W = 11;
    localparam int LIT_W  = IDX_W + 2;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_PRESET = 3'd2;
    localparam logic [2:0] CMD_RUN    = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] VAL_FALSE      = 2'd0;
    localparam logic [1:0] VAL_TRUE       = 2'd1;
    localparam logic [1:0] VAL_UNASSIGNED = 2'd2;

    localparam logic [1:0] MODE_INDEX = 2'd0;
    localparam logic [1:0] MODE_TOTAL = 2'd1;

    localparam logic REG_SCORE_MODE = 1'b0;
    localparam logic REG_NUM_VARS   = 1'b1;

    typedef struct packed {
        logic [2:0]       command;
        logic [IDX_W-1:0] var_index;
        logic             polarity;
        logic             clause_end;
        logic [1:0]       preset_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] var_index_res;
        logic [1:0]       value;
    } t_out_item;

    typedef struct packed {
        logic clr;
        logic sample;
    } t_scan_ctl;

    typedef struct packed {
        logic found;
        logic unassigned;
        logic pos;
    } t_scan_sts;

    typedef enum logic [4:0] {
        S_CLRA, S_IDLE, S_EXEC, S_RDWAIT, S_RCLR,
        S_CL_ADDR, S_CL_EVAL, S_CV_EVAL,
        S_SC_INIT, S_SC_ADDR, S_SC_EVAL, S_PICK,
        S_RL_ADDR, S_RL_EVAL, S_RC_EVAL,
        S_DL_ADDR, S_DL_EVAL, S_DV_EVAL, S_RESP
    } t_state;

endpackage

// ----- rtl/sgda_ram.sv -----
// Generic single-port RAM with registered read.
module sgda_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- rtl/sgda_score.sv -----
// Score unit: scores one variable a cycle while sampling and tracks the best candidate; a preset variable wins over it.
module sgda_score #(
    parameter int MAX_VARS = 1024,
    parameter int VAW      = 10,
    parameter int CNTW     = 13,
    parameter int SW       = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sgda_pkg::t_scan_ctl   i_ctl,
    input  logic [1:0]            i_mode,
    input  logic [VAW-1:0]        i_v,
    input  logic [CNTW-1:0]       i_c0,
    input  logic [CNTW-1:0]       i_c1,
    input  logic                  i_preset,
    output sgda_pkg::t_scan_sts   o_sts,
    output logic [VAW-1:0]        o_pick,
    output logic [CNTW-1:0]       o_c0,
    output logic [CNTW-1:0]       o_c1
);
    import sgda_pkg::*;

    logic            r_p_found, r_b_found, r_b_pos;
    logic [VAW-1:0]  r_p_pick, r_b_pick;
    logic [CNTW-1:0] r_p_c0, r_p_c1, r_b_c0, r_b_c1;
    logic [SW-1:0]   r_best;
    logic [SW-1:0]   score;

    always_comb begin
        case (i_mode)
            MODE_INDEX: score = SW'(MAX_VARS - 1) - SW'(i_v);
            MODE_TOTAL: score = SW'(i_c0) + SW'(i_c1);
            default:    score = (i_c0 > i_c1) ? SW'(i_c0) : SW'(i_c1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_p_found <= 1'b0;
            r_b_found <= 1'b0;
        end else if (i_ctl.sample) begin
            // a later preset has the larger index: it wins
            if (i_preset) begin
                r_p_found <= 1'b1;
                r_p_pick  <= i_v;
                r_p_c0    <= i_c0;
                r_p_c1    <= i_c1;
            end
            if (!r_b_found || score >= r_best) begin
                r_b_found <= 1'b1;
                r_best    <= score;
                r_b_pick  <= i_v;
                r_b_c0    <= i_c0;
                r_b_c1    <= i_c1;
                r_b_pos   <= (i_c1 >= i_c0);
            end
        end
    end

    assign o_sts.found      = r_p_found | r_b_found;
    assign o_sts.unassigned = !r_p_found;
    assign o_sts.pos        = r_b_pos;
    assign o_pick = r_p_found ? r_p_pick : r_b_pick;
    assign o_c0   = r_p_found ? r_p_c0 : r_b_c0;
    assign o_c1   = r_p_found ? r_p_c1 : r_b_c1;
endmodule

// ----- rtl/sat_greedy_dynamic_assign.sv -----
// Top level of the greedy MaxSAT assigner: command sequencer, stores and config port.
//
// Each word on the input channel is one command: clear, add literal, preset
// variable, run, or read variable; each gives exactly one result word. The
// block takes one command at a time and drops ready until that command's
// result is in the output register. A clear sweeps the assignment memory;
// the same sweep runs after reset, during which no command is taken
// (configuration writes still are). A run first sweeps the count and clause
// memories, then counts occurrences of the literals. Each of the nv
// assignment steps then scans all nv variables through the one score unit,
// walks the literal store, and for each clause it retires walks that clause
// again to lower the counts. Every step is bound by the single-port memories.
module sat_greedy_dynamic_assign #(
    parameter int MAX_VARS     = sgda_pkg::MAX_VARS_DEF,
    parameter int MAX_CLAUSES  = sgda_pkg::MAX_CLAUSES_DEF,
    parameter int MAX_LITERALS = sgda_pkg::MAX_LITERALS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sgda_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sgda_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sgda_pkg::*;

    localparam int VAW   = $clog2(MAX_VARS);
    localparam int CAW   = $clog2(MAX_CLAUSES);
    localparam int LAW   = $clog2(MAX_LITERALS);
    localparam int LCW   = $clog2(MAX_LITERALS + 1);
    localparam int CCW   = $clog2(MAX_CLAUSES + 1);
    localparam int NVW   = $clog2(MAX_VARS + 1);
    localparam int CMPW  = (NVW > NVAR_W) ? NVW : NVAR_W;
    localparam int CNTW  = LCW;
    localparam int SW    = (CNTW + 1 > VAW) ? CNTW + 1 : VAW;
    localparam int VWW   = 2 * CNTW + 1;
    localparam int SWPN  = (MAX_VARS > MAX_CLAUSES) ? MAX_VARS : MAX_CLAUSES;
    localparam int SWPW  = $clog2(SWPN);

    // configuration
    logic [1:0]        r_score_mode;
    logic [NVAR_W-1:0] r_num_vars;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_mode <= MODE_TOTAL;
            r_num_vars   <= NVAR_W'(1024);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SCORE_MODE: r_score_mode <= pwdata[1:0];
                REG_NUM_VARS:   r_num_vars   <= pwdata[NVAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_SCORE_MODE: prdata[1:0]        = r_score_mode;
            REG_NUM_VARS:   prdata[NVAR_W-1:0] = r_num_vars;
            default: ;
        endcase
    end

    // effective variable count
    logic [CMPW-1:0] nv;
    assign nv = (CMPW'(r_num_vars) > CMPW'(MAX_VARS)) ? CMPW'(MAX_VARS) : CMPW'(r_num_vars);

    // sequencer state and working registers
    t_state          r_state, n_state;
    t_in_item        r_item;
    t_out_item       r_res;
    logic            r_init;
    logic [SWPW-1:0] r_sweep;
    logic [LCW-1:0]  r_lit_count, r_i, r_j, r_start;
    logic [CCW-1:0]  r_clause_count, r_cls;
    logic [CMPW-1:0] r_v, r_step;
    logic [IDX_W-1:0] r_w;
    logic            r_pol, r_hit;
    logic [VAW-1:0]  r_pick;

    // memory ports
    logic             lit_we, var_we, asg_we, ret_we;
    logic [LAW-1:0]   lit_addr;
    logic [VAW-1:0]   var_addr, asg_addr;
    logic [CAW-1:0]   ret_addr;
    logic [LIT_W-1:0] lit_wdata, lit_rdata;
    logic [VWW-1:0]   var_wdata, var_rdata;
    logic [1:0]       asg_wdata, asg_rdata;
    logic             ret_wdata, ret_rdata;

    sgda_ram #(.W(LIT_W), .D(MAX_LITERALS)) u_lit (
        .i_clk(i_clk), .i_we(lit_we), .i_addr(lit_addr),
        .i_wdata(lit_wdata), .o_rdata(lit_rdata)
    );
    sgda_ram #(.W(VWW), .D(MAX_VARS)) u_var (
        .i_clk(i_clk), .i_we(var_we), .i_addr(var_addr),
        .i_wdata(var_wdata), .o_rdata(var_rdata)
    );
    sgda_ram #(.W(2), .D(MAX_VARS)) u_asg (
        .i_clk(i_clk), .i_we(asg_we), .i_addr(asg_addr),
        .i_wdata(asg_wdata), .o_rdata(asg_rdata)
    );
    sgda_ram #(.W(1), .D(MAX_CLAUSES)) u_ret (
        .i_clk(i_clk), .i_we(ret_we), .i_addr(ret_addr),
        .i_wdata(ret_wdata), .o_rdata(ret_rdata)
    );

    // fields of the word just read from the literal store
    logic [IDX_W-1:0] l_var;
    logic             l_pol, l_end, l_in;
    assign l_var = lit_rdata[LIT_W-1:2];
    assign l_pol = lit_rdata[1];
    assign l_end = lit_rdata[0];
    assign l_in  = CMPW'(l_var) < nv;

    // counts of the variable word just read; done flag on top
    logic            v_done;
    logic [CNTW-1:0] v_c0, v_c1, v_sel, v_inc, v_dec;
    assign v_done = var_rdata[VWW-1];
    assign v_c1   = var_rdata[2*CNTW-1:CNTW];
    assign v_c0   = var_rdata[CNTW-1:0];
    assign v_sel  = r_pol ? v_c1 : v_c0;
    assign v_inc  = v_sel + 1'b1;
    assign v_dec  = (v_sel != '0) ? v_sel - 1'b1 : v_sel;

    // shared score unit
    t_scan_ctl       scan_ctl;
    t_scan_sts       scan_sts;
    logic [VAW-1:0]  pick;
    logic [CNTW-1:0] pick_c0, pick_c1;

    sgda_score #(.MAX_VARS(MAX_VARS), .VAW(VAW), .CNTW(CNTW), .SW(SW)) u_score (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(scan_ctl), .i_mode(r_score_mode),
        .i_v(VAW'(r_v)), .i_c0(v_c0), .i_c1(v_c1),
        .i_preset(asg_rdata != VAL_UNASSIGNED),
        .o_sts(scan_sts), .o_pick(pick), .o_c0(pick_c0), .o_c1(pick_c1)
    );

    // conditions
    logic idx_oor, store_full, lit_more, dl_last, out_free, in_acc;
    assign idx_oor    = CMPW'(r_item.var_index) >= nv;
    assign store_full = (r_lit_count >= LCW'(MAX_LITERALS)) ||
                        (r_clause_count >= CCW'(MAX_CLAUSES));
    assign lit_more   = (r_i < r_lit_count) && (r_cls < r_clause_count);
    assign dl_last    = (r_j == r_i);
    assign out_free   = !o_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // result word registered in the execute cycle; an in-range read takes its value later
    t_out_item exec_res;
    always_comb begin
        exec_res = '{status: ST_OK, var_index_res: '0, value: VAL_FALSE};
        case (r_item.command)
            CMD_ADD: begin
                if (idx_oor) begin
                    exec_res.status = ST_RANGE;
                end else if (store_full) begin
                    exec_res.status = ST_FULL;
                end
            end
            CMD_PRESET: begin
                if (idx_oor) exec_res.status = ST_RANGE;
            end
            CMD_READ: begin
                exec_res.var_index_res = r_item.var_index;
                if (idx_oor) begin
                    exec_res.status = ST_RANGE;
                    exec_res.value  = VAL_UNASSIGNED;
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLRA: begin
                if (r_sweep == SWPW'(MAX_VARS - 1)) n_state = r_init ? S_IDLE : S_RESP;
            end
            S_IDLE: begin
                if (in_acc) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_item.command)
                    CMD_CLEAR: n_state = S_CLRA;
                    CMD_RUN:   n_state = S_RCLR;
                    CMD_READ:  n_state = idx_oor ? S_RESP : S_RDWAIT;
                    default:   n_state = S_RESP;
                endcase
            end
            S_RDWAIT: n_state = S_RESP;
            S_RCLR: begin
                if (r_sweep == SWPW'(SWPN - 1)) n_state = S_CL_ADDR;
            end
            S_CL_ADDR: n_state = lit_more ? S_CL_EVAL : S_SC_INIT;
            S_CL_EVAL: n_state = l_in ? S_CV_EVAL : S_CL_ADDR;
            S_CV_EVAL: n_state = S_CL_ADDR;
            S_SC_INIT: n_state = (r_step < nv) ? S_SC_ADDR : S_RESP;
            S_SC_ADDR: n_state = (r_v < nv) ? S_SC_EVAL : S_PICK;
            S_SC_EVAL: n_state = S_SC_ADDR;
            S_PICK:    n_state = scan_sts.found ? S_RL_ADDR : S_RESP;
            S_RL_ADDR: n_state = lit_more ? S_RL_EVAL : S_SC_INIT;
            S_RL_EVAL: n_state = l_end ? S_RC_EVAL : S_RL_ADDR;
            S_RC_EVAL: n_state = (r_hit && !ret_rdata) ? S_DL_ADDR : S_RL_ADDR;
            S_DL_ADDR: n_state = S_DL_EVAL;
            S_DL_EVAL: begin
                if (l_in)         n_state = S_DV_EVAL;
                else if (dl_last) n_state = S_RL_ADDR;
                else              n_state = S_DL_ADDR;
            end
            S_DV_EVAL: n_state = dl_last ? S_RL_ADDR : S_DL_ADDR;
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        o_in_ready = 1'b0;
        lit_we     = 1'b0;
        lit_addr   = LAW'(r_i);
        lit_wdata  = {r_item.var_index, r_item.polarity, r_item.clause_end};
        var_we     = 1'b0;
        var_addr   = VAW'(r_w);
        var_wdata  = '0;
        asg_we     = 1'b0;
        asg_addr   = VAW'(r_item.var_index);
        asg_wdata  = VAL_UNASSIGNED;
        ret_we     = 1'b0;
        ret_addr   = CAW'(r_cls);
        ret_wdata  = 1'b1;
        scan_ctl   = '0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_CLRA: begin
                asg_we   = 1'b1;
                asg_addr = VAW'(r_sweep);
            end
            S_EXEC: begin
                if (r_item.command == CMD_ADD && !idx_oor && !store_full) begin
                    lit_we   = 1'b1;
                    lit_addr = LAW'(r_lit_count);
                end
                if (r_item.command == CMD_PRESET && !idx_oor) begin
                    asg_we    = 1'b1;
                    asg_wdata = (r_item.preset_value > VAL_UNASSIGNED) ? VAL_UNASSIGNED
                                                                       : r_item.preset_value;
                end
            end
            S_RCLR: begin
                var_we    = (32'(r_sweep) < MAX_VARS);
                var_addr  = VAW'(r_sweep);
                ret_we    = (32'(r_sweep) < MAX_CLAUSES);
                ret_addr  = CAW'(r_sweep);
                ret_wdata = 1'b0;
            end
            S_CL_EVAL, S_DL_EVAL: var_addr = VAW'(l_var);
            S_CV_EVAL: begin
                var_we    = 1'b1;
                var_wdata = r_pol ? {v_done, v_inc, v_c0} : {v_done, v_c1, v_inc};
            end
            S_DV_EVAL: begin
                var_we    = 1'b1;
                var_wdata = r_pol ? {v_done, v_dec, v_c0} : {v_done, v_c1, v_dec};
            end
            S_SC_INIT: scan_ctl.clr = 1'b1;
            S_SC_ADDR: begin
                var_addr = VAW'(r_v);
                asg_addr = VAW'(r_v);
            end
            S_SC_EVAL: scan_ctl.sample = !v_done;
            S_PICK: begin
                // mark done; an unassigned pick takes its majority polarity
                var_we    = scan_sts.found;
                var_addr  = pick;
                var_wdata = {1'b1, pick_c1, pick_c0};
                asg_we    = scan_sts.found && scan_sts.unassigned;
                asg_addr  = pick;
                asg_wdata = scan_sts.pos ? VAL_TRUE : VAL_FALSE;
            end
            S_RC_EVAL: ret_we = r_hit && !ret_rdata;
            S_DL_ADDR: lit_addr = LAW'(r_j);
            default: ;
        endcase
    end

    // sequencer registers and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLRA;
            r_init         <= 1'b1;
            r_sweep        <= '0;
            r_lit_count    <= '0;
            r_clause_count <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLRA: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (n_state != S_CLRA) r_init <= 1'b0;
                end
                S_IDLE: begin
                    if (in_acc) r_item <= i_in_data;
                end
                S_EXEC: begin
                    r_res   <= exec_res;
                    r_sweep <= '0;
                    case (r_item.command)
                        CMD_CLEAR: begin
                            r_lit_count    <= '0;
                            r_clause_count <= '0;
                        end
                        CMD_ADD: begin
                            if (!idx_oor && !store_full) begin
                                r_lit_count <= r_lit_count + 1'b1;
                                if (r_item.clause_end) r_clause_count <= r_clause_count + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_RDWAIT: r_res.value <= asg_rdata;
                S_RCLR: begin
                    r_sweep <= r_sweep + 1'b1;
                    r_i     <= '0;
                    r_cls   <= '0;
                    r_step  <= '0;
                end
                S_CL_EVAL: begin
                    r_i   <= r_i + 1'b1;
                    r_w   <= l_var;
                    r_pol <= l_pol;
                    if (l_end) r_cls <= r_cls + 1'b1;
                end
                S_SC_INIT: r_v <= '0;
                S_SC_EVAL: r_v <= r_v + 1'b1;
                S_PICK: begin
                    r_pick  <= pick;
                    r_i     <= '0;
                    r_cls   <= '0;
                    r_start <= '0;
                    r_hit   <= 1'b0;
                end
                S_RL_ADDR: begin
                    if (!lit_more) r_step <= r_step + 1'b1;
                end
                S_RL_EVAL: begin
                    r_hit <= r_hit || (CMPW'(l_var) == CMPW'(r_pick));
                    if (!l_end) r_i <= r_i + 1'b1;
                end
                S_RC_EVAL: begin
                    if (r_hit && !ret_rdata) begin
                        r_j <= r_start;
                    end else begin
                        r_cls   <= r_cls + 1'b1;
                        r_start <= r_i + 1'b1;
                        r_hit   <= 1'b0;
                        r_i     <= r_i + 1'b1;
                    end
                end
                S_DL_EVAL, S_DV_EVAL: begin
                    if (r_state == S_DL_EVAL) begin
                        r_w   <= l_var;
                        r_pol <= l_pol;
                    end
                    // advance within the clause, or close it once its last word is done
                    if (r_state == S_DV_EVAL || !l_in) begin
                        if (dl_last) begin
                            r_cls   <= r_cls + 1'b1;
                            r_start <= r_i + 1'b1;
                            r_hit   <= 1'b0;
                            r_i     <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // output register: holds a result while the next command is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_RESP && out_free) begin
            o_out_valid <= 1'b1;
            o_out_data  <= r_res;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("command taken while the previous one is still in work");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lit_count <= LCW'(MAX_LITERALS)) && (r_clause_count <= CCW'(MAX_CLAUSES)))
        else $error("literal or clause count beyond store size");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && scan_sts.found) |-> (CMPW'(pick) < nv))
        else $error("picked variable outside the active range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RL_EVAL || r_state == S_RC_EVAL) |-> (r_cls < r_clause_count))
        else $error("clause walk past the last complete clause");

endmodule

// ----- tb/sv/tb_sat_greedy_dynamic_assign.sv -----
// Self-checking testbench of the greedy MaxSAT assigner: directed table, clause-store fill, random episodes.
`timescale 1ns / 100ps

module tb_sat_greedy_dynamic_assign;
    import sgda_pkg::*;

    localparam int NV_CAP    = MAX_VARS_DEF;
    localparam int CLS_CAP   = MAX_CLAUSES_DEF;
    localparam int LIT_CAP   = MAX_LITERALS_DEF;
    localparam int RAND_WORDS = 700;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 40;

    // score modes past the two the package names
    localparam logic [1:0] MODE_MAXPOL     = 2'd2;
    localparam logic [1:0] MODE_MAXPOL_ALT = 2'd3;
    // commands the block ignores
    localparam logic [2:0] CMD_NONE_LO  = 3'd5;
    localparam logic [2:0] CMD_NONE_MID = 3'd6;
    localparam logic [2:0] CMD_NONE_HI  = 3'd7;
    localparam logic [2:0] ADDR_SCORE_MODE = {REG_SCORE_MODE, 2'b00};
    localparam logic [2:0] ADDR_NUM_VARS   = {REG_NUM_VARS, 2'b00};
    localparam logic [1:0] PRESET_ODD = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sat_greedy_dynamic_assign u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 20 ns period, high then low
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the assigner: literal store, counts, assignment.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] sh_lit_var [LIT_CAP];
    logic             sh_lit_pol [LIT_CAP];
    logic             sh_lit_end [LIT_CAP];
    int               sh_lit_cnt;
    int               sh_cls_cnt;
    int               sh_occ     [2*NV_CAP];
    bit               sh_done    [NV_CAP];
    bit               sh_retired [CLS_CAP];
    logic [1:0]       sh_asg     [NV_CAP];
    logic [1:0]       sh_mode;
    logic [NVAR_W-1:0] sh_nvars;

    t_out_item result_fifo [$];
    int        err_cnt = 0;

    function automatic int live_vars();
        return (sh_nvars > NV_CAP) ? NV_CAP : int'(sh_nvars);
    endfunction

    function automatic void wipe_store();
        sh_lit_cnt = 0;
        sh_cls_cnt = 0;
        for (int k = 0; k < 2*NV_CAP; k++) sh_occ[k] = 0;
        for (int k = 0; k < NV_CAP; k++) begin
            sh_done[k] = 1'b0;
            sh_asg[k]  = VAL_UNASSIGNED;
        end
        for (int k = 0; k < CLS_CAP; k++) sh_retired[k] = 1'b0;
    endfunction

    function automatic int var_score(int v);
        int c0;
        int c1;
        c0 = sh_occ[2*v];
        c1 = sh_occ[2*v+1];
        if (sh_mode == MODE_INDEX) return NV_CAP - 1 - v;
        if (sh_mode == MODE_TOTAL) return c0 + c1;
        return (c0 > c1) ? c0 : c1;
    endfunction

    // retire every open clause that holds v and drop its literal counts
    function automatic void retire_for(int v, int nv);
        int first;
        int cls;
        bit hit;
        first = 0;
        cls = 0;
        hit = 1'b0;
        for (int i = 0; i < sh_lit_cnt && cls < sh_cls_cnt; i++) begin
            if (int'(sh_lit_var[i]) == v) hit = 1'b1;
            if (sh_lit_end[i]) begin
                if (hit && !sh_retired[cls]) begin
                    sh_retired[cls] = 1'b1;
                    for (int j = first; j <= i; j++) begin
                        if (int'(sh_lit_var[j]) < nv) begin
                            if (sh_occ[2*sh_lit_var[j] + sh_lit_pol[j]] > 0)
                                sh_occ[2*sh_lit_var[j] + sh_lit_pol[j]]--;
                        end
                    end
                end
                cls++;
                first = i + 1;
                hit = 1'b0;
            end
        end
    endfunction

    function automatic void greedy_assign();
        int nv;
        int cls;
        int pick;
        int best;
        int s;
        bit found;
        nv = live_vars();
        cls = 0;
        for (int k = 0; k < 2*NV_CAP; k++) sh_occ[k] = 0;
        for (int k = 0; k < NV_CAP; k++) sh_done[k] = 1'b0;
        for (int k = 0; k < CLS_CAP; k++) sh_retired[k] = 1'b0;
        // count occurrences over complete clauses only
        for (int i = 0; i < sh_lit_cnt && cls < sh_cls_cnt; i++) begin
            if (int'(sh_lit_var[i]) < nv) sh_occ[2*sh_lit_var[i] + sh_lit_pol[i]]++;
            if (sh_lit_end[i]) cls++;
        end
        for (int step = 0; step < nv; step++) begin
            found = 1'b0;
            pick = 0;
            best = 0;
            // preset variables first, highest index down
            for (int v = nv - 1; v >= 0; v--) begin
                if (!sh_done[v] && sh_asg[v] != VAL_UNASSIGNED) begin
                    pick = v;
                    found = 1'b1;
                    break;
                end
            end
            if (!found) begin
                // best score; >= hands ties to the larger index
                for (int v = 0; v < nv; v++) begin
                    if (sh_done[v]) continue;
                    s = var_score(v);
                    if (!found || s >= best) begin
                        best = s;
                        pick = v;
                        found = 1'b1;
                    end
                end
            end
            if (!found) break;
            sh_done[pick] = 1'b1;
            if (sh_asg[pick] == VAL_UNASSIGNED)
                sh_asg[pick] = (sh_occ[2*pick+1] >= sh_occ[2*pick]) ? VAL_TRUE : VAL_FALSE;
            retire_for(pick, nv);
        end
    endfunction

    // advance the shadow by one command word and return its result word
    function automatic t_out_item predict_result(t_in_item w);
        t_out_item r;
        int nv;
        r = '0;
        nv = live_vars();
        case (w.command)
            CMD_CLEAR: wipe_store();
            CMD_ADD: begin
                if (int'(w.var_index) >= nv) begin
                    r.status = ST_RANGE;
                end else if (sh_lit_cnt >= LIT_CAP || sh_cls_cnt >= CLS_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    sh_lit_var[sh_lit_cnt] = w.var_index;
                    sh_lit_pol[sh_lit_cnt] = w.polarity;
                    sh_lit_end[sh_lit_cnt] = w.clause_end;
                    sh_lit_cnt++;
                    if (w.clause_end) sh_cls_cnt++;
                end
            end
            CMD_PRESET: begin
                if (int'(w.var_index) >= nv) r.status = ST_RANGE;
                else sh_asg[w.var_index] = (w.preset_value == PRESET_ODD) ?
                                           VAL_UNASSIGNED : w.preset_value;
            end
            CMD_RUN: greedy_assign();
            CMD_READ: begin
                r.var_index_res = w.var_index;
                if (int'(w.var_index) >= nv) begin
                    r.status = ST_RANGE;
                    r.value  = VAL_UNASSIGNED;
                end else begin
                    r.value = sh_asg[w.var_index];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_fifo.size() == 0) begin
                report("unexpected result word, status", int'(o_out_data.status), -1);
            end else begin
                want = result_fifo.pop_front();
                if (o_out_data.status !== want.status)
                    report("status", int'(o_out_data.status), int'(want.status));
                if (o_out_data.var_index_res !== want.var_index_res)
                    report("var_index_res", int'(o_out_data.var_index_res),
                           int'(want.var_index_res));
                if (o_out_data.value !== want.value)
                    report("value", int'(o_out_data.value), int'(want.value));
            end
        end
    end

    // hard stop on a hang
    longint cyc_cnt = 0;
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("tb_sat_greedy_dynamic_assign NOT OK");
            $finish;
        end
    end

    // Receiver: stall on its own pattern, switching to a random style and pattern periodically.
    int          rx_cnt = 0;
    int          rx_style = 0;
    logic [31:0] rx_pat = '1;
    always @(negedge i_clk) begin
        rx_cnt++;
        if (rx_cnt % 400 == 0) begin
            rx_style = $urandom_range(0, 2);
            rx_pat = $urandom;
        end
        if (rx_style == 0) i_out_ready = 1'b1;
        else if (rx_style == 1) i_out_ready = rx_pat[5'(rx_cnt % 32)];
        else i_out_ready = (rx_cnt % 7) < 3;
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int burst_left = 0;
    int rand_sent = 0;

    // send one word; all calls start and end on a falling edge
    task automatic send_word(t_in_item w, bit known, t_out_item fixed);
        t_out_item pred;
        int gap;
        pred = predict_result(w);
        result_fifo.insert(result_fifo.size(), known ? fixed : pred);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_cmd(logic [2:0] cmd, int idx, int pol, int last, int pre);
        t_in_item w;
        w = '{command: cmd, var_index: idx[IDX_W-1:0], polarity: pol[0],
              clause_end: last[0], preset_value: pre[1:0]};
        send_word(w, 1'b0, '0);
    endtask

    // hold until every expected word has come back
    task automatic drain();
        while (result_fifo.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write: setup then access, with the block idle
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        drain();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == ADDR_SCORE_MODE) sh_mode = data[1:0];
        else sh_nvars = data[NVAR_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Directed table: a row is either a register write or a command word,
    // with its result typed in where it is obvious.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        is_reg;
        logic [2:0]  addr;
        logic [10:0] data;
        logic        known;
        t_in_item    w;
        t_out_item   e;
    } t_dir_row;

    function automatic t_dir_row row_cmd(logic [2:0] cmd, int idx, int pol, int last,
                                         logic [1:0] pre, int known, logic [1:0] st,
                                         int echo, logic [1:0] val);
        t_dir_row r;
        r = '0;
        r.known = (known != 0);
        r.w = '{command: cmd, var_index: idx[IDX_W-1:0], polarity: pol[0],
                clause_end: last[0], preset_value: pre};
        r.e = '{status: st, var_index_res: echo[IDX_W-1:0], value: val};
        return r;
    endfunction

    function automatic t_dir_row row_reg(logic [2:0] addr, int data);
        t_dir_row r;
        r = '0;
        r.is_reg = 1'b1;
        r.addr = addr;
        r.data = data[10:0];
        return r;
    endfunction

    t_dir_row dir_tab [];

    // one random episode: clear, clauses, presets, run, read back
    task automatic episode();
        int nv;
        int ncls;
        int len;
        int v;
        int lits;
        nv = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        reg_write(ADDR_SCORE_MODE, $urandom_range(0, 3));
        reg_write(ADDR_NUM_VARS, nv);
        send_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        ncls = (nv > 24) ? $urandom_range(1, 12) : $urandom_range(1, 20);
        for (int c = 0; c < ncls; c++) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
                // a few literals out of range, which the block rejects
                v = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, nv - 1);
                send_cmd(CMD_ADD, v, $urandom, int'(k == len - 1), $urandom);
                rand_sent++;
            end
        end
        // sometimes leave a clause open at the tail
        if ($urandom_range(0, 3) == 0) begin
            send_cmd(CMD_ADD, $urandom_range(0, nv - 1), $urandom, 0, $urandom);
            rand_sent++;
        end
        lits = $urandom_range(0, 3);
        for (int k = 0; k < lits; k++) begin
            send_cmd(CMD_PRESET, $urandom_range(0, nv), $urandom, $urandom,
                     $urandom_range(0, 3));
            rand_sent++;
        end
        // noise between the phases
        if ($urandom_range(0, 1) == 0) begin
            send_cmd(3'($urandom_range(int'(CMD_NONE_LO), int'(CMD_NONE_HI))), $urandom,
                     $urandom, $urandom, $urandom);
            send_cmd(CMD_READ, $urandom_range(0, 1023), $urandom, $urandom, $urandom);
            rand_sent += 2;
        end
        // shrink num_vars under the loaded clauses now and then
        if (nv > 1 && $urandom_range(0, 4) == 0) begin
            nv = $urandom_range(1, nv - 1);
            reg_write(ADDR_NUM_VARS, nv);
        end
        for (int pass = 0; pass < 2; pass++) begin
            send_cmd(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
            rand_sent++;
            for (int k = 0; k < nv; k++) begin
                send_cmd(CMD_READ, k, $urandom, $urandom, $urandom);
                rand_sent++;
            end
            if ($urandom_range(0, 2) != 0) break;
            // repeated run: earlier results now count as preset
            for (int k = 0; k < 3; k++) begin
                send_cmd(CMD_ADD, $urandom_range(0, nv - 1), $urandom, int'(k == 2), $urandom);
                rand_sent++;
            end
        end
    endtask

    initial begin
        sh_mode = MODE_TOTAL;
        sh_nvars = NV_CAP;
        for (int k = 0; k < LIT_CAP; k++) begin
            sh_lit_var[k] = '0;
            sh_lit_pol[k] = 1'b0;
            sh_lit_end[k] = 1'b0;
        end
        wipe_store();

        dir_tab = '{
            // after reset: nothing assigned, full index range live
            row_cmd(CMD_READ, 1023, 1, 1, PRESET_ODD, 1, ST_OK, 1023, VAL_UNASSIGNED),
            row_cmd(CMD_READ, 0, 0, 0, VAL_FALSE, 1, ST_OK, 0, VAL_UNASSIGNED),
            row_cmd(CMD_ADD, 1023, 1, 0, PRESET_ODD, 1, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_ADD, 0, 0, 1, VAL_FALSE, 1, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_PRESET, 1023, 0, 0, VAL_TRUE, 1, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_PRESET, 5, 1, 1, PRESET_ODD, 1, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_READ, 5, 0, 0, VAL_FALSE, 1, ST_OK, 5, VAL_UNASSIGNED),
            row_cmd(CMD_READ, 1023, 0, 0, VAL_FALSE, 1, ST_OK, 1023, VAL_TRUE),
            row_cmd(CMD_PRESET, 0, 0, 0, VAL_FALSE, 1, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_READ, 0, 0, 0, VAL_FALSE, 1, ST_OK, 0, VAL_FALSE),
            // ignored commands answer zero
            row_cmd(CMD_NONE_LO, 1023, 1, 1, PRESET_ODD, 1, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_NONE_MID, 512, 0, 1, VAL_UNASSIGNED, 1, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_NONE_HI, 1, 1, 0, VAL_TRUE, 1, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_CLEAR, 1023, 1, 1, PRESET_ODD, 1, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_READ, 1023, 0, 0, VAL_FALSE, 1, ST_OK, 1023, VAL_UNASSIGNED),
            // zero variables: every index is out of range
            row_reg(ADDR_NUM_VARS, 0),
            row_cmd(CMD_READ, 0, 0, 0, VAL_FALSE, 1, ST_RANGE, 0, VAL_UNASSIGNED),
            row_cmd(CMD_ADD, 0, 1, 1, VAL_FALSE, 1, ST_RANGE, 0, VAL_FALSE),
            row_cmd(CMD_PRESET, 0, 0, 0, VAL_TRUE, 1, ST_RANGE, 0, VAL_FALSE),
            // above the cap, the count saturates at the full range
            row_reg(ADDR_NUM_VARS, 2047),
            row_cmd(CMD_READ, 1023, 0, 0, VAL_FALSE, 1, ST_OK, 1023, VAL_UNASSIGNED),
            // single variable, index order
            row_reg(ADDR_NUM_VARS, 1),
            row_reg(ADDR_SCORE_MODE, int'(MODE_INDEX)),
            row_cmd(CMD_ADD, 1, 1, 1, VAL_FALSE, 1, ST_RANGE, 0, VAL_FALSE),
            row_cmd(CMD_ADD, 0, 1, 1, VAL_FALSE, 0, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_RUN, 0, 0, 0, VAL_FALSE, 0, ST_OK, 0, VAL_FALSE),
            row_cmd(CMD_READ, 0, 0, 0, VAL_FALSE, 0, ST_OK, 0, VAL_FALSE)
        };

        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_reg) reg_write(dir_tab[r].addr, 32'(dir_tab[r].data));
            else send_word(dir_tab[r].w, dir_tab[r].known, dir_tab[r].e);
        end

        // clause store full, then a run over 1024 one-literal clauses
        reg_write(ADDR_NUM_VARS, 2);
        reg_write(ADDR_SCORE_MODE, 32'(MODE_MAXPOL));
        send_cmd(CMD_CLEAR, 0, 0, 0, 0);
        for (int k = 0; k < CLS_CAP; k++)
            send_cmd(CMD_ADD, $urandom_range(0, 1), $urandom, 1, $urandom);
        send_cmd(CMD_ADD, 1, 1, 1, 0);
        send_cmd(CMD_RUN, 0, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 0, 0);
        send_cmd(CMD_READ, 1, 0, 0, 0);

        // mode three over the same clauses, results of the first run as presets
        reg_write(ADDR_SCORE_MODE, 32'(MODE_MAXPOL_ALT));
        send_cmd(CMD_RUN, 0, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 0, 0);
        send_cmd(CMD_READ, 1, 0, 0, 0);

        // random episodes until the word budget is spent
        while (rand_sent < RAND_WORDS) episode();

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && result_fifo.size() == 0) begin
            $display("tb_sat_greedy_dynamic_assign OK");
        end else begin
            $display("tb_sat_greedy_dynamic_assign NOT OK");
        end
        $finish;
    end

endmodule
